// ----- rtl/core/hrlh_pkg.sv -----
// hrlh_pkg: shared types and constants for the request line uri hasher
// no dependencies; used by every module in rtl/core and by the testbench

package hrlh_pkg;

	localparam logic [31:0] FNV_OFFSET = 32'h811C_9DC5;
	localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;
	localparam logic [31:0] WORD_GET   = 32'h2054_4547;
	localparam logic [31:0] WORD_POST  = 32'h5453_4F50;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam int           CNT_W       = 9;
	localparam logic [8:0]   CNT_MAX     = 9'd511;
	localparam logic [15:0]  LEN_MAX     = 16'hFFFF;
	localparam logic [7:0]   MAX_LEN_RST = 8'd7;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;
	localparam logic METHOD_GET  = 1'b0;
	localparam logic METHOD_POST = 1'b1;

	typedef enum logic [2:0] {
		PH_METHOD = 3'b001,
		PH_URI    = 3'b010,
		PH_SKIP   = 3'b100
	} phase_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic       final_byte;
	} beat_t;

endpackage

// ----- rtl/core/hrlh_if.sv -----
// hrlh_in_if and hrlh_out_if: valid/ready channels for request bytes and results
// depends on nothing; payload widths are fixed by the field definitions

interface hrlh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface hrlh_out_if;
	logic        valid;
	logic        ready;
	logic        parse_status;
	logic        method_code;
	logic [31:0] uri_hash;
	logic [15:0] uri_length;

	modport source (output valid, output parse_status, output method_code,
		output uri_hash, output uri_length, input ready);
	modport sink   (input valid, input parse_status, input method_code,
		input uri_hash, input uri_length, output ready);
endinterface

// ----- rtl/core/hrlh_in_stage.sv -----
// hrlh_in_stage: input register for one request byte beat
// depends on hrlh_pkg and hrlh_in_if

module hrlh_in_stage
	import hrlh_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	hrlh_in_if.sink       in_ch,
	input  logic          advance,
	output beat_t         beat_s1
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       final_s1;

	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_s1  <= in_ch.data_byte;
			final_s1 <= in_ch.final_byte;
		end
	end

	assign beat_s1 = '{valid: valid_s1, data_byte: data_s1, final_byte: final_s1};

endmodule

// ----- rtl/core/hrlh_parser.sv -----
// hrlh_parser: request line state, fnv-1a hash update and result register
// depends on hrlh_pkg and hrlh_out_if

module hrlh_parser
	import hrlh_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    max_len,
	input  beat_t         beat_s1,
	output logic          advance,
	hrlh_out_if.source    out_ch
);

	phase_t             phase_q, phase_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [31:0]        word_q, word_d;
	logic [31:0]        hash_q, hash_d;
	logic [15:0]        hcnt_q, hcnt_d;
	logic               meth_q, meth_d;

	logic               emit;
	logic               emit_bad;
	logic               rearm;
	logic [7:0]         b;
	logic               fin;
	logic               len_ok;
	logic               is_delim;
	logic [31:0]        mix;

	logic               out_valid_q;
	logic               status_q;
	logic               method_q;
	logic [31:0]        ohash_q;
	logic [15:0]        olen_q;

	assign b   = beat_s1.data_byte;
	assign fin = beat_s1.final_byte;
	assign len_ok = (cnt_q >= 9'd4) && ((cnt_q - 9'd1) <= {1'b0, max_len});
	assign is_delim = (b == CH_SPACE) || (b == CH_QMARK) || (b == CH_CR) || (b == CH_LF);
	assign mix = (hash_q ^ {24'd0, b}) * FNV_PRIME;

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		word_d   = word_q;
		hash_d   = hash_q;
		hcnt_d   = hcnt_q;
		meth_d   = meth_q;
		emit     = 1'b0;
		emit_bad = 1'b0;
		rearm    = 1'b0;
		case (phase_q)
			PH_METHOD: begin
				if (b == CH_SLASH) begin
					if (fin) begin
						emit     = 1'b1;
						emit_bad = 1'b1;
						rearm    = 1'b1;
					end else if (len_ok && word_q == WORD_GET) begin
						meth_d  = METHOD_GET;
						phase_d = PH_URI;
					end else if (len_ok && word_q == WORD_POST) begin
						meth_d  = METHOD_POST;
						phase_d = PH_URI;
					end else begin
						emit     = 1'b1;
						emit_bad = 1'b1;
						phase_d  = PH_SKIP;
					end
				end else begin
					if (cnt_q < 9'd4) begin
						case (cnt_q[1:0])
							2'd0:    word_d = word_q | {24'd0, b};
							2'd1:    word_d = word_q | {16'd0, b, 8'd0};
							2'd2:    word_d = word_q | {8'd0, b, 16'd0};
							default: word_d = word_q | {b, 24'd0};
						endcase
					end
					if (cnt_q < CNT_MAX) begin
						cnt_d = cnt_q + 9'd1;
					end
					if (fin) begin
						emit     = 1'b1;
						emit_bad = 1'b1;
						rearm    = 1'b1;
					end
				end
			end
			PH_URI: begin
				if (is_delim) begin
					emit = 1'b1;
					if (fin) begin
						rearm = 1'b1;
					end else begin
						phase_d = PH_SKIP;
					end
				end else begin
					hash_d = mix;
					if (hcnt_q < LEN_MAX) begin
						hcnt_d = hcnt_q + 16'd1;
					end
					if (fin) begin
						emit     = 1'b1;
						emit_bad = 1'b1;
						rearm    = 1'b1;
					end
				end
			end
			default: begin
				if (fin) begin
					rearm = 1'b1;
				end
			end
		endcase
	end

	assign advance = beat_s1.valid && (!emit || !out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_METHOD;
			cnt_q   <= '0;
			word_q  <= '0;
			hash_q  <= FNV_OFFSET;
			hcnt_q  <= '0;
			meth_q  <= METHOD_GET;
		end else if (advance) begin
			if (rearm) begin
				phase_q <= PH_METHOD;
				cnt_q   <= '0;
				word_q  <= '0;
				hash_q  <= FNV_OFFSET;
				hcnt_q  <= '0;
				meth_q  <= METHOD_GET;
			end else begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				word_q  <= word_d;
				hash_q  <= hash_d;
				hcnt_q  <= hcnt_d;
				meth_q  <= meth_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result uses the state as it stood before this byte's update
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			status_q <= emit_bad ? STATUS_BAD : STATUS_OK;
			method_q <= emit_bad ? METHOD_GET : meth_q;
			ohash_q  <= emit_bad ? 32'd0 : hash_q;
			olen_q   <= emit_bad ? 16'd0 : hcnt_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.parse_status = status_q;
	assign out_ch.method_code  = method_q;
	assign out_ch.uri_hash     = ohash_q;
	assign out_ch.uri_length   = olen_q;

	a_fresh_hash: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_METHOD) |-> (hash_q == FNV_OFFSET && hcnt_q == 16'd0))
		else $error("hash state not at offset basis in method phase");

	a_uri_word: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_URI) |-> (word_q == WORD_GET || word_q == WORD_POST))
		else $error("uri phase entered with an unknown method word");

	a_uri_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_URI) |-> (cnt_q >= 9'd4))
		else $error("uri phase entered with a short method");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == STATUS_BAD) |->
		(method_q == METHOD_GET && ohash_q == 32'd0 && olen_q == 16'd0))
		else $error("bad request result carries nonzero fields");

endmodule

// ----- rtl/core/http_request_line_uri_hasher_top.sv -----
// http_request_line_uri_hasher_top: accepts one request byte per beat and returns one
// result per request. Byte beats enter an input register, and the parse, method check
// and FNV-1a update (one constant 32-bit multiply) run combinationally into a result
// register, so one byte is taken every cycle while no result waits on the output; a
// waiting result stalls only a byte that makes another result, which is held in the
// input register while the input stalls. The user writes max_method_length through
// cfg_we/cfg_wdata while the block is idle; the block does not enforce it. It resets to 7.
// depends on hrlh_pkg, hrlh_if, hrlh_in_stage and hrlh_parser

module http_request_line_uri_hasher_top
	import hrlh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	hrlh_in_if.sink     in_ch,
	hrlh_out_if.source  out_ch
);

	logic [7:0] max_len_q;
	beat_t      beat_s1;
	logic       advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	hrlh_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.advance (advance),
		.beat_s1 (beat_s1)
	);

	hrlh_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.max_len (max_len_q),
		.beat_s1 (beat_s1),
		.advance (advance),
		.out_ch  (out_ch)
	);

endmodule

// ----- bench/http_request_line_uri_hasher_top_test.sv -----
// testbench for http_request_line_uri_hasher_top: request byte beats in, per-request results out
// a scoreboard class predicts each result; depends on hrlh_pkg, hrlh_in_if, hrlh_out_if and the rtl

module http_request_line_uri_hasher_top_test
	import hrlh_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 800000;

	typedef struct packed {
		logic        status;
		logic        method;
		logic [31:0] hash;
		logic [15:0] length;
	} line_result_t;

	class request_line_tracker;
		line_result_t expected_lines[$];
		phase_t       phase;
		logic [8:0]   method_cnt;
		logic [31:0]  lead_word;
		logic [31:0]  hash;
		logic [15:0]  hashed;
		logic         found;
		logic [7:0]   max_len;
		int           errors;

		function new();
			max_len = MAX_LEN_RST;
			errors = 0;
			rearm();
		endfunction

		function void rearm();
			phase = PH_METHOD;
			method_cnt = '0;
			lead_word = '0;
			hash = FNV_OFFSET;
			hashed = '0;
			found = METHOD_GET;
		endfunction

		function void push_line(logic bad);
			line_result_t r;
			r.status = bad ? STATUS_BAD : STATUS_OK;
			r.method = bad ? METHOD_GET : found;
			r.hash = bad ? 32'd0 : hash;
			r.length = bad ? 16'd0 : hashed;
			expected_lines.push_back(r);
		endfunction

		function void take_byte(logic [7:0] b, logic fin);
			logic ok;
			case (phase)
				PH_METHOD: begin
					if (b == CH_SLASH) begin
						if (fin) begin
							push_line(1'b1);
							rearm();
						end else begin
							ok = (method_cnt >= 9'd4) && ((method_cnt - 9'd1) <= {1'b0, max_len});
							if (ok && lead_word == WORD_GET)
								found = METHOD_GET;
							else if (ok && lead_word == WORD_POST)
								found = METHOD_POST;
							else
								ok = 1'b0;
							if (ok) begin
								phase = PH_URI;
							end else begin
								push_line(1'b1);
								phase = PH_SKIP;
							end
						end
					end else begin
						if (method_cnt < 9'd4)
							lead_word = lead_word | ({24'd0, b} << (8 * method_cnt));
						if (method_cnt < CNT_MAX)
							method_cnt = method_cnt + 9'd1;
						if (fin) begin
							push_line(1'b1);
							rearm();
						end
					end
				end
				PH_URI: begin
					if (b == CH_SPACE || b == CH_QMARK || b == CH_CR || b == CH_LF) begin
						push_line(1'b0);
						if (fin)
							rearm();
						else
							phase = PH_SKIP;
					end else begin
						hash = (hash ^ {24'd0, b}) * FNV_PRIME;
						if (hashed < LEN_MAX)
							hashed = hashed + 16'd1;
						if (fin) begin
							push_line(1'b1);
							rearm();
						end
					end
				end
				default: begin
					if (fin)
						rearm();
				end
			endcase
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %0h expected %0h", what, got, want);
			errors++;
		endtask

		task match_result(logic status, logic method, logic [31:0] h, logic [15:0] len);
			line_result_t want;
			if (expected_lines.size() == 0) begin
				report_mismatch("result with none pending", {31'd0, status}, 32'd0);
				return;
			end
			want = expected_lines.pop_front();
			if (status !== want.status)
				report_mismatch("parse_status", {31'd0, status}, {31'd0, want.status});
			if (method !== want.method)
				report_mismatch("method_code", {31'd0, method}, {31'd0, want.method});
			if (h !== want.hash)
				report_mismatch("uri_hash", h, want.hash);
			if (len !== want.length)
				report_mismatch("uri_length", {16'd0, len}, {16'd0, want.length});
		endtask

		function int pending();
			return expected_lines.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;

	hrlh_in_if  in_ch();
	hrlh_out_if out_ch();

	http_request_line_uri_hasher_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	request_line_tracker line_tracker = new();

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_left = 0;
	int cur_max = MAX_LEN_RST;
	int cycles = 0;

	logic [7:0] req_bytes[$];
	logic       req_final[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				line_tracker.max_len = cfg_wdata;
			if (in_ch.valid && in_ch.ready)
				line_tracker.take_byte(in_ch.data_byte, in_ch.final_byte);
			if (out_ch.valid && out_ch.ready)
				line_tracker.match_result(out_ch.parse_status, out_ch.method_code,
					out_ch.uri_hash, out_ch.uri_length);
		end
	end

	// receiver side; a long hold-off lets the block fill up
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	function automatic logic [7:0] method_filler();
		logic [7:0] b;
		do
			b = $urandom_range(0, 255);
		while (b == CH_SLASH);
		return b;
	endfunction

	function automatic logic [7:0] uri_filler();
		logic [7:0] b;
		do
			b = $urandom_range(0, 255);
		while (b == CH_SPACE || b == CH_QMARK || b == CH_CR || b == CH_LF);
		return b;
	endfunction

	function automatic logic [7:0] pick_delim();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_QMARK;
			2: return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	function automatic int pick_method_len();
		int len;
		case ($urandom_range(0, 3))
			0: len = 3;
			1: len = cur_max;
			2: len = cur_max + 1;
			default: len = $urandom_range(3, (cur_max < 3) ? 8 : cur_max + 1);
		endcase
		if (len < 3)
			len = $urandom_range(3, 8);
		if (len > 20 && $urandom_range(0, 3) != 0)
			len = $urandom_range(3, 20);
		return len;
	endfunction

	task add_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			req_bytes.push_back(s[i]);
			req_final.push_back(1'b0);
		end
	endtask

	task add_byte(logic [7:0] b);
		req_bytes.push_back(b);
		req_final.push_back(1'b0);
	endtask

	task build_line(logic [31:0] word, int meth_len, int uri_len, int tail_len);
		for (int i = 0; i < 4; i++)
			add_byte(word[8*i +: 8]);
		for (int i = 0; i < meth_len - 3; i++)
			add_byte(method_filler());
		add_byte(CH_SLASH);
		for (int i = 0; i < uri_len; i++)
			add_byte(uri_filler());
		add_byte(pick_delim());
		for (int i = 0; i < tail_len; i++)
			add_byte($urandom_range(0, 255));
	endtask

	task build_request();
		int kind;
		int cut;
		int uri_len;
		logic [31:0] word;
		req_bytes.delete();
		req_final.delete();
		kind = $urandom_range(0, 99);
		word = $urandom_range(0, 1) ? WORD_POST : WORD_GET;
		uri_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
		if (kind < 65) begin
			build_line(word, pick_method_len(), uri_len, $urandom_range(0, 3));
		end else if (kind < 75) begin
			if ($urandom_range(0, 1))
				word = $urandom();
			else
				word[8*$urandom_range(0, 3) +: 8] = $urandom_range(0, 255);
			build_line(word, pick_method_len(), uri_len, $urandom_range(0, 3));
		end else if (kind < 85) begin
			build_line(word, pick_method_len(), uri_len, 0);
			cut = $urandom_range(1, req_bytes.size() - 1);
			while (req_bytes.size() > cut) begin
				void'(req_bytes.pop_back());
				void'(req_final.pop_back());
			end
		end else if (kind < 93) begin
			for (int i = $urandom_range(1, 12); i > 0; i--) begin
				req_bytes.push_back($urandom_range(0, 255));
				req_final.push_back($urandom_range(0, 5) == 0);
			end
		end else begin
			for (int i = $urandom_range(0, 2); i > 0; i--)
				add_byte(method_filler());
			add_byte(CH_SLASH);
			for (int i = $urandom_range(0, 4); i > 0; i--)
				add_byte($urandom_range(0, 255));
		end
		req_final[req_final.size() - 1] = 1'b1;
	endtask

	task send_beat(logic [7:0] b, logic fin);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.final_byte <= fin;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task send_request();
		foreach (req_bytes[i])
			send_beat(req_bytes[i], req_final[i]);
	endtask

	task send_text(string s);
		req_bytes.delete();
		req_final.delete();
		add_text(s);
		req_final[req_final.size() - 1] = 1'b1;
		send_request();
	endtask

	task drain();
		in_ch.valid <= 1'b0;
		while (line_tracker.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task run_phase(int max_len, int src_pct, int snk_pct, int budget, int hold);
		int sent;
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= max_len[7:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_max = max_len;
		src_idle_pct = src_pct;
		sink_stall_pct = snk_pct;
		hold_left = hold;
		sent = 0;
		while (sent < budget) begin
			build_request();
			sent += req_bytes.size();
			send_request();
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'd0;
		in_ch.final_byte = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_text("/a");
		send_text("x/");
		send_text("G");
		send_text("GET /q");
		send_text("GET /a?");
		req_bytes.delete();
		req_final.delete();
		add_text("POST/");
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(CH_LF);
		req_final[req_final.size() - 1] = 1'b1;
		send_request();

		run_phase(255, 0, 0, 200, 0);
		// method count saturation
		req_bytes.delete();
		req_final.delete();
		for (int i = 0; i < 520; i++)
			add_byte(method_filler());
		req_final[req_final.size() - 1] = 1'b1;
		send_request();

		run_phase(3, 82, 0, 200, 0);
		run_phase($urandom_range(3, 20), 0, 82, 250, 250);
		run_phase(0, 34, 34, 100, 0);
		run_phase($urandom_range(4, 12), 34, 34, 200, 0);
		run_phase(255, 0, 0, 150, 0);

		drain();
		repeat (6) @(negedge clk);
		if (line_tracker.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- http_request_line_uri_hasher_top.f -----
rtl/core/hrlh_pkg.sv
rtl/core/hrlh_if.sv
rtl/core/hrlh_in_stage.sv
rtl/core/hrlh_parser.sv
rtl/core/http_request_line_uri_hasher_top.sv
bench/http_request_line_uri_hasher_top_test.sv
